// ===== sv/emc_pkg.sv =====
// ----------------------------------------------------------------------------
// emc_pkg
// Widths, item codes and defaults for the extent merge coalescer.
// ----------------------------------------------------------------------------
package emc_pkg;

    localparam int MAX_SEGMENT_PAGES_DEF = 256;
    localparam int SECTORS_PER_PAGE_DEF  = 8;

    localparam int SECTOR_W   = 48;
    localparam int PAGES_W    = 9;
    localparam int ID_W       = 32;
    localparam int INFLIGHT_W = 16;
    localparam int KIND_W     = 2;

    // s_tdata: sector, pages, id -> 89 bits, padded to 96
    localparam int S_TDATA_W = 96;
    // m_tdata: start, page count, extent count, id, in-flight, throttle -> 115, padded to 120
    localparam int M_TDATA_W = 120;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [KIND_W-1:0] KIND_EXTENT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FLUSH    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COMPLETE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;

    localparam logic [KIND_W-1:0] RES_SEGMENT  = 2'd0;
    localparam logic [KIND_W-1:0] RES_REJECT   = 2'd1;
    localparam logic [KIND_W-1:0] RES_INFLIGHT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE_EN    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INFLIGHT_LIMIT = 1'd1;

    localparam logic [INFLIGHT_W-1:0] INFLIGHT_LIMIT_RST = 16'd256;

    typedef logic [SECTOR_W-1:0]   lba_t;
    typedef logic [PAGES_W-1:0]    pages_t;
    typedef logic [INFLIGHT_W-1:0] inflight_t;

endpackage

// ===== sv/extent_merge_coalescer.sv =====
// ----------------------------------------------------------------------------
// extent_merge_coalescer
// Merges adjacent storage extents into I/O segments and tracks pages in flight.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one item per handshake; s_tuser selects extent, flush or
//   completion, s_tdata carries sector, page count and id.
//   m_ channel: zero or one result item per input item; m_tuser gives the
//   result kind (segment issued, extent rejected, in-flight update).
//   cfg channel: register writes (index 0 throttle enable, 1 in-flight
//   limit), ready whenever out of reset; write only while the block is idle.
// Timing:
//   An item is registered on entry and processed from the input register
//   once the result register is free or being taken; its result is loaded
//   into the result register, which presents it. One item per cycle is
//   sustained while m_tready keeps up; the segment state update is
//   combinational adds and compares against the registered segment.
// Reset (aresetn low, synchronous): no open segment, zero pages in flight,
//   throttle disabled, limit 256, both channels empty, no channel ready.
// Stall: while a held result waits on m_tready nothing is processed;
//   s_tready drops while the input register is occupied and cannot advance.
// ----------------------------------------------------------------------------
module extent_merge_coalescer #(
    parameter int MAX_SEGMENT_PAGES = emc_pkg::MAX_SEGMENT_PAGES_DEF,
    parameter int SECTORS_PER_PAGE  = emc_pkg::SECTORS_PER_PAGE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [emc_pkg::S_TDATA_W-1:0] s_tdata,  // extent_sector, extent_pages, id
    input  logic [emc_pkg::KIND_W-1:0]    s_tuser,  // kind

    output logic                          m_tvalid,
    input  logic                          m_tready,
    // segment_start, segment_page_count, segment_extent_count, rejected_id,
    // inflight_pages, throttle
    output logic [emc_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [emc_pkg::KIND_W-1:0]    m_tuser,  // result_kind

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [emc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [emc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import emc_pkg::*;

    localparam logic [PAGES_W:0]  MAX_PG  = (PAGES_W+1)'(MAX_SEGMENT_PAGES);
    localparam logic [15:0]       SPP_16  = 16'(SECTORS_PER_PAGE);

    // configuration
    logic      throttle_en_reg;
    inflight_t limit_reg;

    // input register
    logic              in_valid_reg;
    logic [KIND_W-1:0] in_kind_reg;
    lba_t              in_sector_reg;
    pages_t            in_pages_reg;
    logic [ID_W-1:0]   in_id_reg;

    // segment state
    logic      open_reg;
    lba_t      first_reg;
    pages_t    seg_pages_reg;
    pages_t    seg_ext_reg;
    inflight_t pif_reg;

    // result register
    logic              m_valid_reg;
    logic [KIND_W-1:0] m_kind_reg;
    lba_t              m_start_reg;
    pages_t            m_pc_reg;
    pages_t            m_ec_reg;
    logic [ID_W-1:0]   m_id_reg;
    inflight_t         m_pif_reg;
    logic              m_thr_reg;

    logic advance;
    logic s_accept;

    // processing logic
    logic [15:0]       ext_span;
    logic [15:0]       seg_span;
    lba_t              ext_end;
    lba_t              seg_end;
    logic [PAGES_W:0]  sum_pages;
    logic              bad_extent;
    logic              front;
    logic              back;
    logic              merge_ok;

    logic              open_next;
    lba_t              first_next;
    pages_t            seg_pages_next;
    pages_t            seg_ext_next;
    inflight_t         pif_next;

    logic              issue;
    lba_t              iss_start;
    pages_t            iss_pages;
    pages_t            iss_ext;
    logic [INFLIGHT_W:0] pif_sum;

    logic              has_res;
    logic [KIND_W-1:0] res_kind;
    logic [ID_W-1:0]   res_id;
    logic              res_thr;

    assign advance   = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = aresetn && (!in_valid_reg || advance);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = aresetn;

    assign ext_span  = 16'(in_pages_reg) * SPP_16;
    assign seg_span  = 16'(seg_pages_reg) * SPP_16;
    assign ext_end   = in_sector_reg + SECTOR_W'(ext_span);
    assign seg_end   = first_reg + SECTOR_W'(seg_span);
    assign sum_pages = {1'b0, seg_pages_reg} + {1'b0, in_pages_reg};

    assign bad_extent = in_id_reg[ID_W-1] || (in_pages_reg == '0)
                        || ({1'b0, in_pages_reg} > MAX_PG);
    assign front    = (ext_end == first_reg);
    assign back     = !front && (seg_end == in_sector_reg);
    assign merge_ok = open_reg && (sum_pages <= MAX_PG) && (front || back);

    always_comb begin
        open_next      = open_reg;
        first_next     = first_reg;
        seg_pages_next = seg_pages_reg;
        seg_ext_next   = seg_ext_reg;
        pif_next       = pif_reg;
        issue          = 1'b0;
        iss_start      = first_reg;
        iss_pages      = seg_pages_reg;
        iss_ext        = seg_ext_reg;
        has_res        = 1'b0;
        res_kind       = RES_SEGMENT;
        res_id         = '0;
        pif_sum        = '0;

        case (in_kind_reg)
            KIND_COMPLETE: begin
                has_res  = 1'b1;
                res_kind = RES_INFLIGHT;
                pif_next = (INFLIGHT_W'(in_pages_reg) >= pif_reg) ? '0
                           : pif_reg - INFLIGHT_W'(in_pages_reg);
            end
            KIND_FLUSH: begin
                if (open_reg) begin
                    issue          = 1'b1;
                    open_next      = 1'b0;
                    first_next     = '0;
                    seg_pages_next = '0;
                    seg_ext_next   = '0;
                end
            end
            KIND_EXTENT: begin
                if (bad_extent) begin
                    has_res  = 1'b1;
                    res_kind = RES_REJECT;
                    res_id   = in_id_reg;
                end else if (merge_ok) begin
                    if (front) begin
                        first_next = in_sector_reg;
                    end
                    seg_pages_next = sum_pages[PAGES_W-1:0];
                    seg_ext_next   = seg_ext_reg + PAGES_W'(1);
                    if (sum_pages >= MAX_PG) begin
                        issue          = 1'b1;
                        iss_start      = first_next;
                        iss_pages      = seg_pages_next;
                        iss_ext        = seg_ext_next;
                        open_next      = 1'b0;
                        first_next     = '0;
                        seg_pages_next = '0;
                        seg_ext_next   = '0;
                    end
                end else begin
                    issue          = open_reg;
                    open_next      = 1'b1;
                    first_next     = in_sector_reg;
                    seg_pages_next = in_pages_reg;
                    seg_ext_next   = PAGES_W'(1);
                end
            end
            default: begin
            end
        endcase

        if (issue) begin
            has_res  = 1'b1;
            res_kind = RES_SEGMENT;
            pif_sum  = {1'b0, pif_reg} + (INFLIGHT_W+1)'(iss_pages);
            pif_next = pif_sum[INFLIGHT_W] ? '1 : pif_sum[INFLIGHT_W-1:0];
        end

        res_thr = throttle_en_reg && (pif_next >= limit_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            throttle_en_reg <= 1'b0;
            limit_reg       <= INFLIGHT_LIMIT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_THROTTLE_EN:    throttle_en_reg <= cfg_data[0];
                CFG_INFLIGHT_LIMIT: limit_reg       <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_kind_reg   <= s_tuser;
            in_sector_reg <= s_tdata[47:0];
            in_pages_reg  <= s_tdata[56:48];
            in_id_reg     <= s_tdata[88:57];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg      <= 1'b0;
            first_reg     <= '0;
            seg_pages_reg <= '0;
            seg_ext_reg   <= '0;
            pif_reg       <= '0;
        end else if (advance) begin
            open_reg      <= open_next;
            first_reg     <= first_next;
            seg_pages_reg <= seg_pages_next;
            seg_ext_reg   <= seg_ext_next;
            pif_reg       <= pif_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= has_res;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && has_res) begin
            m_kind_reg  <= res_kind;
            m_start_reg <= issue ? iss_start : '0;
            m_pc_reg    <= issue ? iss_pages : '0;
            m_ec_reg    <= issue ? iss_ext : '0;
            m_id_reg    <= res_id;
            m_pif_reg   <= pif_next;
            m_thr_reg   <= res_thr;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {5'b0, m_thr_reg, m_pif_reg, m_id_reg, m_ec_reg, m_pc_reg, m_start_reg};

    // an open segment never holds more than the page cap; a closed one is empty
    a_seg_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, seg_pages_reg} <= MAX_PG)
        else $error("segment exceeds page cap");

    a_closed_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !open_reg |-> (seg_pages_reg == '0 && seg_ext_reg == '0 && first_reg == '0))
        else $error("closed segment holds state");

    a_issue_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_kind_reg == RES_SEGMENT) |-> (m_pc_reg != '0 && m_ec_reg != '0))
        else $error("empty segment issued");

    a_throttle_en: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_thr_reg) |-> throttle_en_reg)
        else $error("throttle flagged while disabled");

    a_inflight_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && has_res) |=> (m_pif_reg == pif_reg))
        else $error("reported in-flight count differs from state");

endmodule
